@@ sv/lba_pkg.sv @@
package lba_pkg;

  // default sizes of the label space and the bitmap word
  localparam int LABEL_BITS_DEF = 16;
  localparam int WORD_BITS_DEF  = 32;

  // fixed field widths
  localparam int FIELD_W   = 16;
  localparam int CFG_W     = 8;
  localparam int MAX_LABEL = 65535;

  localparam logic [CFG_W-1:0] LOWEST_RESET = 8'd16;

  // operation codes
  localparam logic OP_ALLOC = 1'b0;
  localparam logic OP_FREE  = 1'b1;

  // status codes
  localparam logic STAT_OK   = 1'b0;
  localparam logic STAT_FAIL = 1'b1;

  typedef struct packed {
    logic               operation;
    logic [FIELD_W-1:0] label;
  } req_t;

  typedef struct packed {
    logic [FIELD_W-1:0] result_label;
    logic               status;
  } rsp_t;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_DIV,
    S_FREE_RD,
    S_FREE_WR,
    S_SCAN,
    S_DONE
  } state_t;

endpackage

@@ sv/lba_chan_if.sv @@
interface lba_chan_if #(
  parameter type payload_t = logic
) ();
  logic     valid;
  logic     ready;
  payload_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

@@ sv/label_bitmap_allocator.sv @@
// channel    dir  payload                        handshake
// request    in   operation, label               valid/ready
// response   out  result_label, status           valid/ready
// cfg        in   lowest_label (8 bits)          cfg_we, no ready
//
// allocate reads the bitmap one word per cycle until a free bit turns up, at most
// MAP_WORDS words (2048 at the default sizes)
// free splits the label into word and bit by a reciprocal multiply, then
// reads and writes the word; an out-of-range free fails without either
// after reset the bitmap is cleared one word a cycle, ready low
// a finished word waits in the response register; the next result stalls until taken
module label_bitmap_allocator #(
  parameter int LABEL_BITS = lba_pkg::LABEL_BITS_DEF,
  parameter int WORD_BITS  = lba_pkg::WORD_BITS_DEF
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      cfg_we,
  input  logic [lba_pkg::CFG_W-1:0] cfg_wdata,
  lba_chan_if.sink                  request,
  lba_chan_if.source                response
);
  import lba_pkg::*;

  localparam int LAB_W     = (LABEL_BITS < FIELD_W) ? LABEL_BITS : FIELD_W;
  localparam int MAP_WORDS = ((1 << LABEL_BITS) + WORD_BITS - 1) / WORD_BITS;
  localparam int ADDR_W    = $clog2(MAP_WORDS);
  localparam int BIT_W     = $clog2(WORD_BITS);
  localparam int BASE_W    = LABEL_BITS + 1;
  localparam int TOP_LABEL = (LABEL_BITS >= FIELD_W) ? MAX_LABEL : (1 << LABEL_BITS) - 1;
  localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(MAP_WORDS - 1);

  state_t              state, state_next;
  logic [ADDR_W-1:0]   chk_addr, chk_addr_next;
  logic [ADDR_W-1:0]   scan_addr, scan_addr_next;
  logic [BASE_W-1:0]   base, base_next;
  logic [CFG_W-1:0]    lowest, lowest_next;
  logic [FIELD_W-1:0]  res_label, res_label_next;
  logic                res_status, res_status_next;
  logic                rsp_valid, rsp_valid_next;
  logic [FIELD_W-1:0]  rsp_label, rsp_label_next;
  logic                rsp_status, rsp_status_next;

  logic                mem_we;
  logic [ADDR_W-1:0]   mem_waddr;
  logic [WORD_BITS-1:0] mem_wdata;
  logic [ADDR_W-1:0]   mem_raddr;
  logic [WORD_BITS-1:0] rd_data;

  logic                div_start;
  logic                div_done;
  logic [LAB_W-1:0]    div_quo;
  logic [BIT_W-1:0]    div_rem;
  logic [ADDR_W-1:0]   free_addr;
  logic [WORD_BITS-1:0] free_bit;

  logic                found;
  logic [WORD_BITS-1:0] grant;
  logic [BIT_W-1:0]    idx;
  logic                at_top;

  logic [FIELD_W-1:0]  req_label;
  logic                in_range;

  // bitmap storage
  lba_mem #(
    .DEPTH  (MAP_WORDS),
    .WIDTH  (WORD_BITS),
    .ADDR_W (ADDR_W)
  ) u_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (mem_raddr),
    .rdata (rd_data)
  );

  // label to word index and bit position
  lba_div #(
    .N     (LAB_W),
    .D     (WORD_BITS),
    .BIT_W (BIT_W)
  ) u_div (
    .clk       (clk),
    .rst       (rst),
    .start     (div_start),
    .dividend  (LAB_W'(request.payload.label)),
    .done      (div_done),
    .quotient  (div_quo),
    .remainder (div_rem)
  );

  // first free label in the word under test
  lba_word_search #(
    .WIDTH     (WORD_BITS),
    .BIT_W     (BIT_W),
    .BASE_W    (BASE_W),
    .TOP_LABEL (TOP_LABEL)
  ) u_search (
    .word   (rd_data),
    .base   (base),
    .lowest (lowest),
    .found  (found),
    .grant  (grant),
    .idx    (idx),
    .at_top (at_top)
  );

  assign req_label = request.payload.label;
  assign in_range  = (FIELD_W'(lowest) <= req_label) && ((req_label >> LAB_W) == '0);
  assign free_addr = ADDR_W'(div_quo);
  assign free_bit  = WORD_BITS'(1) << div_rem;

  assign request.ready         = (state == S_IDLE);
  assign response.valid        = rsp_valid;
  assign response.payload.result_label = rsp_label;
  assign response.payload.status       = rsp_status;

  // sequencer
  always_comb begin
    state_next      = state;
    chk_addr_next   = chk_addr;
    scan_addr_next  = scan_addr;
    base_next       = base;
    res_label_next  = res_label;
    res_status_next = res_status;
    rsp_valid_next  = rsp_valid && !response.ready;
    rsp_label_next  = rsp_label;
    rsp_status_next = rsp_status;
    lowest_next     = cfg_we ? cfg_wdata : lowest;
    mem_we          = 1'b0;
    mem_waddr       = chk_addr;
    mem_wdata       = '0;
    mem_raddr       = '0;
    div_start       = 1'b0;

    case (state)
      S_CLEAR: begin
        mem_we = 1'b1;
        if (chk_addr == LAST_ADDR) begin
          state_next = S_IDLE;
        end else begin
          chk_addr_next = chk_addr + ADDR_W'(1);
        end
      end

      S_IDLE: begin
        // word 0 is read here so the scan starts with data in hand
        mem_raddr = '0;
        if (request.valid) begin
          if (request.payload.operation == OP_ALLOC) begin
            chk_addr_next  = '0;
            scan_addr_next = (LAST_ADDR == '0) ? '0 : ADDR_W'(1);
            base_next      = '0;
            state_next     = S_SCAN;
          end else if (in_range) begin
            div_start  = 1'b1;
            state_next = S_DIV;
          end else begin
            res_label_next  = '0;
            res_status_next = STAT_FAIL;
            state_next      = S_DONE;
          end
        end
      end

      S_DIV: begin
        if (div_done) begin
          state_next = S_FREE_RD;
        end
      end

      S_FREE_RD: begin
        mem_raddr  = free_addr;
        state_next = S_FREE_WR;
      end

      S_FREE_WR: begin
        mem_we          = 1'b1;
        mem_waddr       = free_addr;
        mem_wdata       = rd_data & ~free_bit;
        res_label_next  = '0;
        res_status_next = STAT_OK;
        state_next      = S_DONE;
      end

      S_SCAN: begin
        mem_raddr = scan_addr;
        if (found) begin
          mem_we          = 1'b1;
          mem_waddr       = chk_addr;
          mem_wdata       = rd_data | grant;
          res_label_next  = FIELD_W'(base + BASE_W'(idx));
          res_status_next = STAT_OK;
          state_next      = S_DONE;
        end else if (at_top || chk_addr == LAST_ADDR) begin
          res_label_next  = '0;
          res_status_next = STAT_FAIL;
          state_next      = S_DONE;
        end else begin
          chk_addr_next  = chk_addr + ADDR_W'(1);
          base_next      = base + BASE_W'(WORD_BITS);
          scan_addr_next = (scan_addr == LAST_ADDR) ? scan_addr : scan_addr + ADDR_W'(1);
        end
      end

      S_DONE: begin
        if (!rsp_valid || response.ready) begin
          rsp_valid_next  = 1'b1;
          rsp_label_next  = res_label;
          rsp_status_next = res_status;
          state_next      = S_IDLE;
        end
      end

      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLEAR;
      chk_addr  <= '0;
      lowest    <= LOWEST_RESET;
      rsp_valid <= 1'b0;
    end else begin
      state     <= state_next;
      chk_addr  <= chk_addr_next;
      lowest    <= lowest_next;
      rsp_valid <= rsp_valid_next;
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    scan_addr  <= scan_addr_next;
    base       <= base_next;
    res_label  <= res_label_next;
    res_status <= res_status_next;
    rsp_label  <= rsp_label_next;
    rsp_status <= rsp_status_next;
  end

`ifndef ASSERT_OFF
  // a new response word only comes out of the done state
  a_rsp_from_done: assert property (@(posedge clk) disable iff (rst)
    $rose(response.valid) |-> $past(state == S_DONE))
    else $error("response raised outside the done state");

  // the bitmap is never written while waiting for a request
  a_no_write_idle: assert property (@(posedge clk) disable iff (rst)
    (state == S_IDLE) |-> !mem_we)
    else $error("bitmap written while idle");

  // a failure always carries label zero
  a_fail_zero: assert property (@(posedge clk) disable iff (rst)
    (response.valid && response.payload.status == STAT_FAIL) |->
      (response.payload.result_label == '0))
    else $error("failed response with nonzero label");

  // a grant marks exactly one bit
  a_grant_onehot: assert property (@(posedge clk) disable iff (rst)
    (state == S_SCAN && found) |-> $onehot(grant))
    else $error("grant is not a single bit");
`endif

endmodule

@@ sv/lba_mem.sv @@
module lba_mem #(
  parameter int DEPTH  = 2048,
  parameter int WIDTH  = 32,
  parameter int ADDR_W = 11
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [WIDTH-1:0]  wdata,
  input  logic [ADDR_W-1:0] raddr,
  output logic [WIDTH-1:0]  rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

@@ sv/lba_div.sv @@
module lba_div #(
  parameter int N     = 16,
  parameter int D     = 32,
  parameter int BIT_W = 5
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic [N-1:0]     dividend,
  output logic             done,
  output logic [N-1:0]     quotient,
  output logic [BIT_W-1:0] remainder
);

  localparam int SH     = N + $clog2(D);
  localparam int MULT   = ((1 << SH) + D - 1) / D;
  localparam int PROD_W = 2 * N + 2;

  logic              step;
  logic [N-1:0]      num;
  logic [N-1:0]      q;
  logic [BIT_W-1:0]  r;
  logic [PROD_W-1:0] prod;
  logic [N-1:0]      qd;

  // quotient from the scaled reciprocal of the divisor, exact over N bits
  assign prod = PROD_W'(dividend) * PROD_W'(MULT);

  // quotient times divisor, taken off the dividend for the remainder
  assign qd = q * N'(D);

  // step control: quotient on start, remainder in the cycle after
  always_ff @(posedge clk) begin
    if (rst) begin
      step <= 1'b0;
      done <= 1'b0;
    end else begin
      step <= start;
      done <= step;
    end
  end

  // quotient and remainder registers
  always_ff @(posedge clk) begin
    if (start) begin
      num <= dividend;
      q   <= N'(prod >> SH);
    end
    if (step) begin
      r <= BIT_W'(num - qd);
    end
  end

  assign quotient  = q;
  assign remainder = r;

endmodule

@@ sv/lba_word_search.sv @@
module lba_word_search #(
  parameter int WIDTH     = 32,
  parameter int BIT_W     = 5,
  parameter int BASE_W    = 17,
  parameter int TOP_LABEL = 65535
) (
  input  logic [WIDTH-1:0]         word,
  input  logic [BASE_W-1:0]        base,
  input  logic [lba_pkg::CFG_W-1:0] lowest,
  output logic                     found,
  output logic [WIDTH-1:0]         grant,
  output logic [BIT_W-1:0]         idx,
  output logic                     at_top
);
  import lba_pkg::*;

  logic [BASE_W-1:0] low_ext;
  logic [BASE_W-1:0] hi;
  logic [BASE_W-1:0] top;
  logic [WIDTH-1:0]  ones;
  logic [WIDTH-1:0]  low_mask;
  logic [WIDTH-1:0]  top_mask;
  logic [WIDTH-1:0]  avail;

  assign low_ext = BASE_W'(lowest);
  assign hi      = base + BASE_W'(WIDTH - 1);
  assign top     = BASE_W'(TOP_LABEL);
  assign ones    = '1;
  assign at_top  = (hi >= top);

  // drop bits of labels below the lowest label
  always_comb begin
    if (base >= low_ext) begin
      low_mask = ones;
    end else if (hi < low_ext) begin
      low_mask = '0;
    end else begin
      low_mask = ones << (low_ext - base);
    end
  end

  // drop bits of labels above the top of the label space
  always_comb begin
    if (hi <= top) begin
      top_mask = ones;
    end else if (base > top) begin
      top_mask = '0;
    end else begin
      top_mask = ~(ones << (top - base + BASE_W'(1)));
    end
  end

  // lowest free bit: isolate it, then encode its position
  assign avail = ~word & low_mask & top_mask;
  assign grant = avail & (~avail + WIDTH'(1));
  assign found = |avail;

  always_comb begin
    idx = '0;
    for (int i = 0; i < WIDTH; i++) begin
      if (grant[i]) begin
        idx = idx | BIT_W'(i);
      end
    end
  end

endmodule

@@ tb/label_bitmap_allocator_tb.sv @@
module label_bitmap_allocator_tb;
  import lba_pkg::*;

  localparam int QUIET_LIMIT = 20000;

  // tracks label ownership and the words the allocator should return
  class label_book;
    bit                 in_use [MAX_LABEL+1];
    logic [CFG_W-1:0]   lowest;
    rsp_t               awaited [$];
    logic [FIELD_W-1:0] granted [$];
    int unsigned        mismatches;
    int unsigned        seen;
    int unsigned        n_alloc;
    int unsigned        n_alloc_ok;
    int unsigned        n_free;
    int unsigned        n_free_bad;
    int unsigned        cfg_writes;

    function new();
      lowest = LOWEST_RESET;
    endfunction

    function void set_lowest(logic [CFG_W-1:0] v);
      lowest = v;
      cfg_writes++;
    endfunction

    function int unsigned pending();
      return awaited.size();
    endfunction

    // first fit from lowest upward; free clears the bit of the label itself
    function void note_request(req_t r);
      rsp_t        e;
      int unsigned lab;
      bit          found;
      e.result_label = '0;
      e.status       = STAT_FAIL;
      found          = 1'b0;
      if (r.operation == OP_ALLOC) begin
        n_alloc++;
        for (lab = 32'(lowest); lab <= MAX_LABEL && !found; lab++) begin
          if (!in_use[FIELD_W'(lab)]) begin
            in_use[FIELD_W'(lab)] = 1'b1;
            e.result_label        = FIELD_W'(lab);
            e.status              = STAT_OK;
            found                 = 1'b1;
            granted.push_back(FIELD_W'(lab));
            n_alloc_ok++;
          end
        end
      end else begin
        n_free++;
        // the top label is 65535, so only the lower bound can reject
        if (r.label >= FIELD_W'(lowest)) begin
          in_use[r.label] = 1'b0;
          e.status        = STAT_OK;
        end else begin
          n_free_bad++;
        end
      end
      awaited.push_back(e);
    endfunction

    function void check_response(rsp_t got);
      rsp_t e;
      seen++;
      if (awaited.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("word %0d: unexpected, label %h status %0d", seen, got.result_label,
                   got.status);
      end else begin
        e = awaited.pop_front();
        if (got.result_label !== e.result_label || got.status !== e.status) begin
          mismatches++;
          if (mismatches <= 10)
            $display("word %0d: result_label exp %h got %h, status exp %0d got %0d", seen,
                     e.result_label, got.result_label, e.status, got.status);
        end
      end
    endfunction

    // hand back a label from the granted list, or a random one up to 300 if it is empty
    function logic [FIELD_W-1:0] take_held();
      int unsigned        i;
      logic [FIELD_W-1:0] lab;
      if (granted.size() == 0) return FIELD_W'($urandom_range(0, 300));
      i   = $urandom_range(0, granted.size() - 1);
      lab = granted[i];
      granted.delete(i);
      return lab;
    endfunction
  endclass

  logic             clk = 1'b0;
  logic             rst;
  logic             cfg_we;
  logic [CFG_W-1:0] cfg_wdata;
  int unsigned      quiet_cycles = 0;
  bit               steady = 1'b0;
  label_book        book;

  lba_chan_if #(.payload_t(req_t)) req_if ();
  lba_chan_if #(.payload_t(rsp_t)) rsp_if ();

  label_bitmap_allocator u_top (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .request   (req_if),
    .response  (rsp_if)
  );

  always #5 clk = ~clk;

  // mostly short gaps, now and then a long one
  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 92) return $urandom_range(1, 4);
    return $urandom_range(15, 70);
  endfunction

  function automatic req_t mk(logic op, logic [FIELD_W-1:0] lab);
    req_t r;
    r.operation = op;
    r.label     = lab;
    return r;
  endfunction

  // offer one request word and wait for it to be taken
  task automatic offer(req_t r);
    int unsigned gap;
    gap = steady ? 0 : pick_gap();
    if (gap != 0) begin
      req_if.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req_if.valid   <= 1'b1;
    req_if.payload <= r;
    do @(posedge clk); while (!req_if.ready);
    book.note_request(r);
  endtask

  // hold off until every outstanding response is back
  task automatic settle();
    req_if.valid <= 1'b0;
    while (book.pending() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_lowest(logic [CFG_W-1:0] v);
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we    <= 1'b0;
    book.set_lowest(v);
  endtask

  task automatic random_item(int unsigned alloc_pct);
    int unsigned        pick;
    logic [FIELD_W-1:0] edge_lab;
    pick = $urandom_range(0, 99);
    if (pick < alloc_pct) begin
      offer(mk(OP_ALLOC, FIELD_W'($urandom)));
    end else if (pick < alloc_pct + 25) begin
      offer(mk(OP_FREE, book.take_held()));
    end else if (pick < alloc_pct + 33) begin
      offer(mk(OP_FREE, FIELD_W'($urandom)));
    end else begin
      case ($urandom_range(0, 3))
        0:       edge_lab = FIELD_W'(book.lowest) - FIELD_W'(1);
        1:       edge_lab = FIELD_W'(book.lowest);
        2:       edge_lab = FIELD_W'(book.lowest) + FIELD_W'(1);
        default: edge_lab = FIELD_W'(MAX_LABEL);
      endcase
      offer(mk(OP_FREE, edge_lab));
    end
  endtask

  // response sink with random back-pressure
  initial begin
    int unsigned run;
    int unsigned hold;
    rsp_if.ready <= 1'b0;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      run = $urandom_range(1, 40);
      rsp_if.ready <= 1'b1;
      repeat (run) @(posedge clk);
      hold = steady ? 0 : pick_gap();
      if (hold != 0) begin
        rsp_if.ready <= 1'b0;
        repeat (hold) @(posedge clk);
      end
    end
  end

  // response checking and handshake watchdog
  always @(posedge clk) begin
    if (!rst && rsp_if.valid && rsp_if.ready) book.check_response(rsp_if.payload);
    if (rst || (req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("watchdog: no handshake for %0d cycles", quiet_cycles);
      $display("TEST FAILED");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    int unsigned      ph;
    int unsigned      k;
    int unsigned      n_items;
    int unsigned      alloc_pct;
    logic [CFG_W-1:0] lo;
    book           = new();
    rst            <= 1'b1;
    cfg_we         <= 1'b0;
    cfg_wdata      <= '0;
    req_if.valid   <= 1'b0;
    req_if.payload <= '0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // reset value of lowest_label, range edges, repeated and top-label frees
    offer(mk(OP_ALLOC, 16'h0000));
    offer(mk(OP_ALLOC, 16'hFFFF));
    offer(mk(OP_FREE, 16'd16));
    offer(mk(OP_ALLOC, 16'h1234));
    offer(mk(OP_FREE, 16'd15));
    offer(mk(OP_FREE, 16'hFFFF));
    offer(mk(OP_FREE, 16'h0000));
    offer(mk(OP_FREE, 16'hAAAA));
    offer(mk(OP_FREE, 16'h5555));
    offer(mk(OP_FREE, 16'd17));
    offer(mk(OP_FREE, 16'd17));
    settle();

    // lowest at zero: labels below the old floor become reachable
    write_lowest(8'd0);
    offer(mk(OP_ALLOC, 16'h0000));
    offer(mk(OP_ALLOC, 16'h0000));
    offer(mk(OP_ALLOC, 16'h0000));
    offer(mk(OP_FREE, 16'd0));
    settle();

    // lowest at the top: old grants stay marked and cannot be freed
    write_lowest(8'd255);
    offer(mk(OP_ALLOC, 16'h0000));
    offer(mk(OP_FREE, 16'd254));
    offer(mk(OP_FREE, 16'd2));
    offer(mk(OP_FREE, 16'd255));
    settle();

    // back to zero: allocation skips labels still marked from before
    write_lowest(8'd0);
    offer(mk(OP_ALLOC, 16'h0000));
    offer(mk(OP_ALLOC, 16'h0000));
    offer(mk(OP_ALLOC, 16'h0000));

    // random phases, each with its own floor; phases 3 and 5 change the alloc/free mix
    for (ph = 0; ph < 8; ph++) begin
      settle();
      case (ph)
        0:       lo = 8'd255;
        1:       lo = 8'd0;
        2:       lo = LOWEST_RESET;
        default: lo = CFG_W'($urandom_range(0, 255));
      endcase
      write_lowest(lo);
      steady    = ($urandom_range(0, 3) == 0);
      alloc_pct = (ph == 3) ? 62 : (ph == 5) ? 30 : 45;
      n_items   = $urandom_range(30, 38);
      for (k = 0; k < n_items; k++) begin
        random_item(alloc_pct);
        if ($urandom_range(0, 39) == 0) settle();
      end
    end

    // drain and leave time for any stray response
    settle();
    repeat (64) @(posedge clk);

    $display("%0d requests: %0d allocates (%0d granted), %0d frees (%0d out of range)",
             book.n_alloc + book.n_free, book.n_alloc, book.n_alloc_ok, book.n_free,
             book.n_free_bad);
    $display("%0d lowest_label writes, %0d responses checked, %0d mismatches",
             book.cfg_writes, book.seen, book.mismatches);
    if (book.mismatches == 0 && book.pending() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("%0d responses never arrived", book.pending());
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
